>>> hdl/ssrb_pkg.sv
`default_nettype none

package ssrb_pkg;

  // Ring store geometry.
  localparam int STORE_DEPTH = 32;
  localparam int PTR_W       = $clog2(STORE_DEPTH);
  localparam int AVAIL_W     = 5;
  localparam int CNT_W       = (PTR_W > AVAIL_W) ? PTR_W : AVAIL_W;

  // Sample format: three bytes per channel, low 18 bits kept.
  localparam int SAMPLE_W     = 18;
  localparam int BYTES_PER_CH = 3;
  localparam int POS_W        = 3;
  localparam int PART_W       = 16;

  localparam logic [POS_W-1:0] LAST_POS_ONE = POS_W'(BYTES_PER_CH - 1);
  localparam logic [POS_W-1:0] LAST_POS_TWO = POS_W'(2 * BYTES_PER_CH - 1);
  localparam logic [1:0]       LEDS_RESET   = 2'd2;

  typedef logic [PTR_W-1:0]    ptr_t;
  typedef logic [SAMPLE_W-1:0] sample_t;

  // Place of a byte inside its channel value.
  typedef enum logic [1:0] {
    PH_HIGH,
    PH_MID,
    PH_LOW
  } phase_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_req_t;

  typedef struct packed {
    logic [AVAIL_W-1:0] available;
    sample_t            oldest_red;
    sample_t            oldest_ir;
    sample_t            newest_red;
    sample_t            newest_ir;
    logic               sample_done;
  } out_rsp_t;

  // Update produced by the control logic for one accepted request.
  typedef struct packed {
    logic               wr_red;
    logic               wr_ir;
    sample_t            wdata;
    ptr_t               head;
    ptr_t               tail;
    logic [AVAIL_W-1:0] available;
    logic               done;
  } upd_t;

  function automatic phase_e chan_phase(input logic [POS_W-1:0] pos);
    logic [POS_W-1:0] p;
    phase_e           ph;
    p = (pos >= POS_W'(BYTES_PER_CH)) ? pos - POS_W'(BYTES_PER_CH) : pos;
    case (p)
      POS_W'(0): ph = PH_HIGH;
      POS_W'(1): ph = PH_MID;
      default:   ph = PH_LOW;
    endcase
    return ph;
  endfunction

  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == PTR_W'(STORE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

`default_nettype wire

>>> hdl/sensor_sample_ring_buffer.sv
// Ring buffer for three-byte-per-channel optical sensor samples.
// Input channel: in_valid_i / in_stall_o carry one request per accepted edge,
// either a raw sensor byte (kind 0) or an advance of the oldest pointer
// (kind 1). Each request yields exactly one result on out_valid_o /
// out_stall_i with the waiting count, the oldest and newest red and IR
// samples, and a flag set when the byte completed a whole sample.
// One request is taken every cycle while the output side keeps up; the ring
// store's registered read ports form the first stage and the output register
// the second, and a result is offered once it has passed through both.
// The channel count register is written through cfg_we_i / cfg_wdata_i; the
// user must write it only while the block is idle; this is not enforced. A
// write restarts byte assembly at a sample boundary. Reset clears the
// pointers, the assembly state and the per-entry valid bits, so every store
// entry reads as zero until written; the register returns to two channels.
// When the receiver stalls, the result holds in the output register and one
// more request can still be accepted into the read stage; after that the
// input side stalls until the output drains.
`default_nettype none

module sensor_sample_ring_buffer (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire ssrb_pkg::in_req_t in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output ssrb_pkg::out_rsp_t     out_rsp_o,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_wdata_i
);

  ssrb_pkg::upd_t     upd;
  ssrb_pkg::out_rsp_t s1_rsp, out_q;
  ssrb_pkg::sample_t  red_head, red_tail, ir_head, ir_tail;
  logic               acc, s2_ld, s1_adv;
  logic               s1_valid_q, s1_valid_d, out_valid_q, out_valid_d;
  logic [ssrb_pkg::AVAIL_W-1:0] s1_avail_q;
  logic               s1_done_q;

  // Handshake: the read stage moves on whenever the output register is free
  // or being emptied; the input stalls only when the read stage is stuck.
  assign s2_ld      = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && s2_ld;
  assign in_stall_o = s1_valid_q && !s2_ld;
  assign acc        = in_valid_i && !in_stall_o;
  assign s1_valid_d = acc || (s1_valid_q && !s2_ld);
  assign out_valid_d = s1_adv || (out_valid_q && out_stall_i);

  // Byte assembly, pointer updates and the waiting count.
  ssrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .req_i       (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .upd_o       (upd)
  );

  // One ring store per channel, read at the new head and tail.
  ssrb_store u_red (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (acc),
    .we_i       (upd.wr_red),
    .wdata_i    (upd.wdata),
    .head_i     (upd.head),
    .tail_i     (upd.tail),
    .head_val_o (red_head),
    .tail_val_o (red_tail)
  );

  ssrb_store u_ir (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (acc),
    .we_i       (upd.wr_ir),
    .wdata_i    (upd.wdata),
    .head_i     (upd.head),
    .tail_i     (upd.tail),
    .head_val_o (ir_head),
    .tail_val_o (ir_tail)
  );

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_avail_q <= upd.available;
      s1_done_q  <= upd.done;
    end
  end

  always_comb begin
    s1_rsp.available   = s1_avail_q;
    s1_rsp.oldest_red  = red_tail;
    s1_rsp.oldest_ir   = ir_tail;
    s1_rsp.newest_red  = red_head;
    s1_rsp.newest_ir   = ir_head;
    s1_rsp.sample_done = s1_done_q;
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= s1_rsp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef NO_ASSERTIONS
  // The input side only stalls behind a request held in the read stage.
  a_stall_needs_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with room in the pipeline");

  // An advance request never reports a completed sample.
  a_adv_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_req_i.kind |=> s1_valid_q && !s1_done_q)
    else $error("advance request flagged a completed sample");

  // A request leaving the read stage shows up at the output next cycle.
  a_s1_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_o)
    else $error("result lost between read stage and output");
`endif

endmodule

`default_nettype wire

>>> hdl/ssrb_ctrl.sv
`default_nettype none

module ssrb_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              acc_i,
  input  wire ssrb_pkg::in_req_t req_i,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_wdata_i,
  output ssrb_pkg::upd_t         upd_o
);

  logic [1:0]                  leds_q, leds_d;
  logic [ssrb_pkg::POS_W-1:0]  pos_q, pos_d, pos, last;
  logic [ssrb_pkg::PART_W-1:0] part_q, part_d;
  ssrb_pkg::ptr_t              head_q, head_d, tail_q, tail_d;
  ssrb_pkg::phase_e            ph;
  ssrb_pkg::sample_t           val;
  logic                        wr_red, wr_ir, done;
  logic [ssrb_pkg::PTR_W:0]    diff;
  logic [ssrb_pkg::CNT_W-1:0]  cnt;

  always_comb begin
    last   = leds_q[1] ? ssrb_pkg::LAST_POS_TWO : ssrb_pkg::LAST_POS_ONE;
    pos    = (pos_q > last) ? '0 : pos_q;
    ph     = ssrb_pkg::chan_phase(pos);
    val    = {part_q[9:0], req_i.data_byte};
    pos_d  = pos_q;
    part_d = part_q;
    head_d = head_q;
    tail_d = tail_q;
    wr_red = 1'b0;
    wr_ir  = 1'b0;
    done   = 1'b0;
    if (acc_i) begin
      if (!req_i.kind) begin
        if (pos == '0) begin
          head_d = ssrb_pkg::ptr_inc(head_q);
        end
        case (ph)
          ssrb_pkg::PH_HIGH: part_d = {8'h00, req_i.data_byte};
          ssrb_pkg::PH_MID:  part_d = {part_q[7:0], req_i.data_byte};
          ssrb_pkg::PH_LOW: begin
            if (pos < ssrb_pkg::POS_W'(ssrb_pkg::BYTES_PER_CH)) begin
              wr_red = 1'b1;
            end else begin
              wr_ir = 1'b1;
            end
          end
          default: ;
        endcase
        if (pos == last) begin
          pos_d = '0;
          done  = 1'b1;
        end else begin
          pos_d = pos + ssrb_pkg::POS_W'(1);
        end
      end else if (head_q != tail_q) begin
        tail_d = ssrb_pkg::ptr_inc(tail_q);
      end
    end
    leds_d = leds_q;
    if (cfg_we_i) begin
      leds_d = cfg_wdata_i;
      pos_d  = '0;
      part_d = '0;
    end
  end

  // Waiting count of the ring after this update.
  always_comb begin
    if (head_d >= tail_d) begin
      diff = {1'b0, head_d} - {1'b0, tail_d};
    end else begin
      diff = {1'b0, head_d} + (ssrb_pkg::PTR_W + 1)'(ssrb_pkg::STORE_DEPTH) - {1'b0, tail_d};
    end
    cnt = ssrb_pkg::CNT_W'(diff[ssrb_pkg::PTR_W-1:0]);
  end

  always_comb begin
    upd_o.wr_red    = wr_red;
    upd_o.wr_ir     = wr_ir;
    upd_o.wdata     = val;
    upd_o.head      = head_d;
    upd_o.tail      = tail_d;
    upd_o.available = cnt[ssrb_pkg::AVAIL_W-1:0];
    upd_o.done      = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leds_q <= ssrb_pkg::LEDS_RESET;
      pos_q  <= '0;
      part_q <= '0;
      head_q <= '0;
      tail_q <= '0;
    end else begin
      leds_q <= leds_d;
      pos_q  <= pos_d;
      part_q <= part_d;
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

`ifndef NO_ASSERTIONS
  // An advance request never moves the head.
  a_adv_keeps_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && req_i.kind |=> head_q == $past(head_q))
    else $error("head moved on an advance request");

  // A data byte never moves the tail.
  a_byte_keeps_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && !req_i.kind |=> tail_q == $past(tail_q))
    else $error("tail moved on a data byte");
`endif

endmodule

`default_nettype wire

>>> hdl/ssrb_store.sv
`default_nettype none

module ssrb_store (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              we_i,
  input  wire ssrb_pkg::sample_t wdata_i,
  input  wire ssrb_pkg::ptr_t    head_i,
  input  wire ssrb_pkg::ptr_t    tail_i,
  output ssrb_pkg::sample_t      head_val_o,
  output ssrb_pkg::sample_t      tail_val_o
);

  ssrb_pkg::sample_t                 mem [ssrb_pkg::STORE_DEPTH];
  logic [ssrb_pkg::STORE_DEPTH-1:0]  vld_q;
  ssrb_pkg::sample_t                 rd_head_q, rd_tail_q, wdata_q;
  logic                              vld_head_q, vld_tail_q, fwd_head_q, fwd_tail_q;

  // Writes land at the head; both reads return the contents before the write.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[head_i] <= wdata_i;
      end
      rd_head_q <= mem[head_i];
      rd_tail_q <= mem[tail_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i && we_i) begin
      vld_q[head_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wdata_q    <= wdata_i;
      vld_head_q <= vld_q[head_i];
      vld_tail_q <= vld_q[tail_i];
      fwd_head_q <= we_i;
      fwd_tail_q <= we_i && (tail_i == head_i);
    end
  end

  assign head_val_o = fwd_head_q ? wdata_q : (vld_head_q ? rd_head_q : '0);
  assign tail_val_o = fwd_tail_q ? wdata_q : (vld_tail_q ? rd_tail_q : '0);

`ifndef NO_ASSERTIONS
  // A value written at the head is what the head read shows next.
  a_head_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && we_i |=> head_val_o == $past(wdata_i))
    else $error("written sample not visible at head");
`endif

endmodule

`default_nettype wire
